// ----- rtl/first_fit_block_allocator_assert.svh -----
// Assertion macros for the first-fit block allocator checker.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ffa_pkg.sv -----
// Shared types and constants for the first-fit block allocator.
// No dependencies.
package ffa_pkg;

	localparam int ADDR_BITS = 16;
	localparam int LEN_BITS  = ADDR_BITS + 1;
	localparam logic [LEN_BITS-1:0] HEAP_RESET = LEN_BITS'(65536);
	localparam logic [LEN_BITS-1:0] HEAP_MAX   = {1'b1, {ADDR_BITS{1'b0}}};

	typedef struct packed {
		logic                 mode;
		logic [LEN_BITS-1:0]  request_size;
		logic [ADDR_BITS-1:0] block_address;
	} ffa_req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [ADDR_BITS-1:0] granted_address;
	} ffa_res_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] off;
		logic [LEN_BITS-1:0]  len;
		logic                 used;
	} ffa_entry_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_INIT,
		CELL_WRITE,
		CELL_SPLIT,
		CELL_DEL1,
		CELL_DEL2
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		ffa_entry_t a;
		ffa_entry_t b;
	} ffa_cmd_t;

	typedef enum logic [2:0] {
		STAT_OK       = 3'd0,
		STAT_NO_FIT   = 3'd1,
		STAT_FULL     = 3'd2,
		STAT_ZERO     = 3'd3,
		STAT_NOT_FOUND = 3'd4
	} ffa_status_t;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC,
		S_FREE_SCAN,
		S_FREE_NEXT
	} ffa_state_t;

endpackage

// ----- rtl/ffa_cell.sv -----
// One table entry of the allocator chain: holds a block and shifts to and from neighbours.
// Depends on ffa_pkg.
module ffa_cell #(
	parameter int IDX_W = 4,
	parameter int INDEX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ffa_pkg::ffa_cmd_t cmd,
	input  logic [IDX_W-1:0]  pos,
	input  ffa_pkg::ffa_entry_t left,
	input  ffa_pkg::ffa_entry_t right,
	input  ffa_pkg::ffa_entry_t right2,
	output ffa_pkg::ffa_entry_t ent
);
	import ffa_pkg::*;

	localparam logic [IDX_W:0] J = INDEX[IDX_W:0];
	localparam ffa_entry_t RST = (INDEX == 0) ?
		ffa_entry_t'{off: '0, len: HEAP_RESET, used: 1'b0} : ffa_entry_t'('0);

	logic [IDX_W:0] pe;
	ffa_entry_t     ent_q;
	ffa_entry_t     ent_d;

	assign pe  = {1'b0, pos};
	assign ent = ent_q;

	always_comb begin
		ent_d = ent_q;
		case (cmd.op)
			CELL_INIT: begin
				ent_d = (INDEX == 0) ? cmd.a : '0;
			end
			CELL_WRITE: begin
				if (J == pe) ent_d = cmd.a;
			end
			CELL_SPLIT: begin
				if (J == pe) ent_d = cmd.a;
				else if (J == pe + (IDX_W+1)'(1)) ent_d = cmd.b;
				else if (J > pe + (IDX_W+1)'(1)) ent_d = left;
			end
			CELL_DEL1: begin
				if (J + (IDX_W+1)'(1) == pe) ent_d = cmd.a;
				else if (J >= pe) ent_d = right;
			end
			CELL_DEL2: begin
				if (J + (IDX_W+1)'(1) == pe) ent_d = cmd.a;
				else if (J >= pe) ent_d = right2;
			end
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= RST;
		end else begin
			ent_q <= ent_d;
		end
	end

endmodule

// ----- rtl/first_fit_block_allocator.sv -----
// channel   direction  handshake             payload
// request   in         start & !busy         ffa_req_t  (mode, request_size, block_address)
// result    out        done, one cycle       ffa_res_t  (status, granted_address)
// config    in         cfg_valid & cfg_ready heap_size, 17 bits
// A zero-size allocate gives its result in the cycle after acceptance; otherwise the scan
// reads the table entries in order (up to MAX_BLOCKS), ends with a check past the last entry
// when nothing is found, and a found free goes on through S_FREE_NEXT for the merge.
// The scan walks the cell chain one entry per cycle; inserts and merges shift the chain at once.
// Reset leaves one free block covering 65536 bytes; a heap_size write does the same for its size, clamped to 1..65536.
// cfg_ready is high only while idle. The result receiver cannot stall.
// Top level of the first-fit block allocator; depends on ffa_pkg and ffa_cell.
module first_fit_block_allocator #(
	parameter int MAX_BLOCKS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  ffa_pkg::ffa_req_t           request,
	output logic                        done,
	output ffa_pkg::ffa_res_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ffa_pkg::LEN_BITS-1:0] cfg_data
);
	import ffa_pkg::*;

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BLOCKS);

	ffa_entry_t ent [MAX_BLOCKS];
	ffa_cmd_t   cmd;
	logic [IDX_W-1:0] pos;

	ffa_state_t state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d, cnt_q, cnt_d;
	logic [LEN_BITS-1:0]  req_q, req_d;
	logic [ADDR_BITS-1:0] addr_q, addr_d;
	ffa_entry_t prev_q, prev_d, cur_q, cur_d, rd;
	logic done_q, done_d;
	ffa_res_t res_q, res_d;
	logic [LEN_BITS-1:0] heap_cl;
	logic lf, rf;

	genvar g;
	generate
		for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
			ffa_entry_t nl, nr, nr2;
			if (g > 0) begin : g_l
				assign nl = ent[g-1];
			end else begin : g_l0
				assign nl = '0;
			end
			if (g + 1 < MAX_BLOCKS) begin : g_r
				assign nr = ent[g+1];
			end else begin : g_r0
				assign nr = '0;
			end
			if (g + 2 < MAX_BLOCKS) begin : g_r2
				assign nr2 = ent[g+2];
			end else begin : g_r20
				assign nr2 = '0;
			end
			ffa_cell #(.IDX_W(IDX_W), .INDEX(g)) u_cell (
				.clk(clk), .arst_n(arst_n), .cmd(cmd), .pos(pos),
				.left(nl), .right(nr), .right2(nr2), .ent(ent[g])
			);
		end
	endgenerate

	assign rd        = ent[idx_q[IDX_W-1:0]];
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign done      = done_q;
	assign result    = res_q;

	always_comb begin
		if (cfg_data == '0) heap_cl = LEN_BITS'(1);
		else if (cfg_data > HEAP_MAX) heap_cl = HEAP_MAX;
		else heap_cl = cfg_data;
	end

	assign lf = (idx_q != CNT_W'(1)) && !prev_q.used;
	assign rf = (idx_q < cnt_q) && !rd.used;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cnt_d   = cnt_q;
		req_d   = req_q;
		addr_d  = addr_q;
		prev_d  = prev_q;
		cur_d   = cur_q;
		done_d  = 1'b0;
		res_d   = res_q;
		cmd     = '{op: CELL_HOLD, a: '0, b: '0};
		pos     = '0;
		case (state_q)
			S_IDLE: begin
				if (cfg_valid) begin
					cmd.op = CELL_INIT;
					cmd.a  = '{off: '0, len: heap_cl, used: 1'b0};
					cnt_d  = CNT_W'(1);
				end
				if (start) begin
					req_d  = request.request_size;
					addr_d = request.block_address;
					idx_d  = '0;
					if (request.mode == MODE_FREE) begin
						state_d = S_FREE_SCAN;
					end else if (request.request_size == '0) begin
						done_d = 1'b1;
						res_d  = '{status: STAT_ZERO, granted_address: '0};
					end else begin
						state_d = S_ALLOC;
					end
				end
			end
			S_ALLOC: begin
				pos = idx_q[IDX_W-1:0];
				if (idx_q == cnt_q) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
					res_d   = '{status: STAT_NO_FIT, granted_address: '0};
				end else if (!rd.used && rd.len >= req_q) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
					if (rd.len == req_q) begin
						cmd.op = CELL_WRITE;
						cmd.a  = '{off: rd.off, len: rd.len, used: 1'b1};
						res_d  = '{status: STAT_OK, granted_address: rd.off};
					end else if (cnt_q == CNT_FULL) begin
						res_d  = '{status: STAT_FULL, granted_address: '0};
					end else begin
						cmd.op = CELL_SPLIT;
						cmd.a  = '{off: rd.off, len: req_q, used: 1'b1};
						cmd.b  = '{off: rd.off + req_q[ADDR_BITS-1:0],
							len: rd.len - req_q, used: 1'b0};
						cnt_d  = cnt_q + CNT_W'(1);
						res_d  = '{status: STAT_OK, granted_address: rd.off};
					end
				end else begin
					idx_d = idx_q + CNT_W'(1);
				end
			end
			S_FREE_SCAN: begin
				if (idx_q == cnt_q) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
					res_d   = '{status: STAT_NOT_FOUND, granted_address: '0};
				end else begin
					idx_d = idx_q + CNT_W'(1);
					if (rd.off == addr_q) begin
						cur_d   = rd;
						state_d = S_FREE_NEXT;
					end else begin
						prev_d = rd;
					end
				end
			end
			S_FREE_NEXT: begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				res_d   = '{status: STAT_OK, granted_address: '0};
				pos     = IDX_W'(idx_q - CNT_W'(1));
				if (lf && rf) begin
					cmd.op = CELL_DEL2;
					cmd.a  = '{off: prev_q.off, len: prev_q.len + cur_q.len + rd.len,
						used: 1'b0};
					cnt_d  = cnt_q - CNT_W'(2);
				end else if (lf) begin
					cmd.op = CELL_DEL1;
					cmd.a  = '{off: prev_q.off, len: prev_q.len + cur_q.len, used: 1'b0};
					cnt_d  = cnt_q - CNT_W'(1);
				end else if (rf) begin
					cmd.op = CELL_DEL1;
					pos    = idx_q[IDX_W-1:0];
					cmd.a  = '{off: cur_q.off, len: cur_q.len + rd.len, used: 1'b0};
					cnt_d  = cnt_q - CNT_W'(1);
				end else begin
					cmd.op = CELL_WRITE;
					cmd.a  = '{off: cur_q.off, len: cur_q.len, used: 1'b0};
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			cnt_q   <= CNT_W'(1);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		req_q  <= req_d;
		addr_q <= addr_d;
		prev_q <= prev_d;
		cur_q  <= cur_d;
		res_q  <= res_d;
	end

endmodule

// ----- rtl/ffa_checker.sv -----
// Port-level checker for the first-fit block allocator, bound to the top level.
// Depends on ffa_pkg and first_fit_block_allocator_assert.svh.
`include "first_fit_block_allocator_assert.svh"
module ffa_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input ffa_pkg::ffa_req_t            request,
	input logic                         done,
	input ffa_pkg::ffa_res_t            result,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic [ffa_pkg::LEN_BITS-1:0] cfg_data
);
	import ffa_pkg::*;

	`FFA_ASSERT_NXT(a_accept_moves, start && !busy, busy || done, "accepted item went nowhere")
	`FFA_ASSERT_IMP(a_done_idle, done, !busy, "result while still busy")
	`FFA_ASSERT_IMP(a_grant_zero, done && (result.status != STAT_OK), result.granted_address == '0,
		"address granted on failure")
	`FFA_ASSERT_IMP(a_cfg_idle, busy, !cfg_ready, "config open while busy")

endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the first-fit block allocator: a queued driver,
// a result monitor and an in-bench model of the block table and heap size.
// Depends on ffa_pkg and first_fit_block_allocator.
`timescale 1ns / 100ps

module tb_top;
	import ffa_pkg::*;

	localparam int NBLK = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	ffa_req_t request = '0;
	logic done;
	ffa_res_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LEN_BITS-1:0] cfg_data = '0;

	first_fit_block_allocator #(.MAX_BLOCKS(NBLK)) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the block table
	logic [ADDR_BITS-1:0] tbl_off [NBLK];
	logic [LEN_BITS-1:0]  tbl_len [NBLK];
	logic                 tbl_used [NBLK];
	int                   tbl_count;

	ffa_req_t pending_items [$];
	ffa_res_t expected_results [$];
	int mismatches = 0;
	int idle_pct = 11;
	bit cfg_req = 1'b0;
	logic [LEN_BITS-1:0] cfg_value;
	bit cfg_written;

	function automatic void reset_table(input logic [LEN_BITS-1:0] hsize);
		for (int i = 0; i < NBLK; i++) begin
			tbl_off[i] = '0;
			tbl_len[i] = '0;
			tbl_used[i] = 1'b0;
		end
		tbl_len[0] = hsize;
		tbl_count = 1;
	endfunction

	function automatic void coalesce_free();
		int w;
		w = 0;
		for (int i = 0; i < tbl_count; i++) begin
			if (w > 0 && !tbl_used[i] && !tbl_used[w-1]) begin
				tbl_len[w-1] = tbl_len[w-1] + tbl_len[i];
			end else begin
				tbl_off[w] = tbl_off[i];
				tbl_len[w] = tbl_len[i];
				tbl_used[w] = tbl_used[i];
				w++;
			end
		end
		for (int i = w; i < NBLK; i++) begin
			tbl_off[i] = '0;
			tbl_len[i] = '0;
			tbl_used[i] = 1'b0;
		end
		tbl_count = w;
	endfunction

	function automatic ffa_res_t allocate_or_free(input ffa_req_t it);
		ffa_res_t r;
		r.status = STAT_OK;
		r.granted_address = '0;
		if (it.mode == MODE_ALLOC) begin
			if (it.request_size == 0) begin
				r.status = STAT_ZERO;
			end else begin
				r.status = STAT_NO_FIT;
				for (int i = 0; i < tbl_count; i++) begin
					if (tbl_used[i] || tbl_len[i] < it.request_size) continue;
					if (tbl_len[i] == it.request_size) begin
						tbl_used[i] = 1'b1;
						r.granted_address = tbl_off[i];
						r.status = STAT_OK;
					end else if (tbl_count >= NBLK) begin
						r.status = STAT_FULL;
					end else begin
						for (int k = tbl_count; k > i + 1; k--) begin
							tbl_off[k] = tbl_off[k-1];
							tbl_len[k] = tbl_len[k-1];
							tbl_used[k] = tbl_used[k-1];
						end
						tbl_off[i+1] = tbl_off[i] + it.request_size[ADDR_BITS-1:0];
						tbl_len[i+1] = tbl_len[i] - it.request_size;
						tbl_used[i+1] = 1'b0;
						tbl_len[i] = it.request_size;
						tbl_used[i] = 1'b1;
						tbl_count++;
						r.granted_address = tbl_off[i];
						r.status = STAT_OK;
					end
					break;
				end
			end
		end else begin
			r.status = STAT_NOT_FOUND;
			for (int i = 0; i < tbl_count; i++) begin
				if (tbl_off[i] == it.block_address) begin
					tbl_used[i] = 1'b0;
					coalesce_free();
					r.status = STAT_OK;
					break;
				end
			end
		end
		return r;
	endfunction

	// driver: hold start until accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.insert(expected_results.size(), allocate_or_free(request));
				void'(pending_items.pop_front());
			end
			if ((start && busy) || (pending_items.size() > 0 &&
				$urandom_range(99) >= idle_pct)) begin
				if (!(start && busy)) request <= pending_items[0];
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				cfg_valid <= 1'b0;
				cfg_written = 1'b1;
			end else if (cfg_req && !cfg_valid && !cfg_written) begin
				cfg_data <= cfg_value;
				cfg_valid <= 1'b1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %0d/%0h", result.status,
					result.granted_address);
			end else begin
				ffa_res_t e;
				e = expected_results.pop_front();
				if (result !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0h got %0d/%0h", e.status,
							e.granted_address, result.status, result.granted_address);
				end
			end
		end
	end

	task automatic drain();
		while (pending_items.size() != 0 || expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_heap(input logic [LEN_BITS-1:0] v);
		logic [LEN_BITS-1:0] c;
		drain();
		cfg_value = v;
		cfg_written = 1'b0;
		cfg_req = 1'b1;
		while (!cfg_written) @(posedge clk);
		cfg_req = 1'b0;
		c = (v == '0) ? LEN_BITS'(1) : (v > HEAP_MAX ? HEAP_MAX : v);
		reset_table(c);
	endtask

	function automatic ffa_req_t mk(input logic m, input logic [LEN_BITS-1:0] sz,
		input logic [ADDR_BITS-1:0] a);
		ffa_req_t it;
		it.mode = m;
		it.request_size = sz;
		it.block_address = a;
		return it;
	endfunction

	task automatic add_item(input ffa_req_t it);
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic drain_peek(input logic [ADDR_BITS-1:0] a);
		add_item(mk(MODE_FREE, LEN_BITS'($urandom), a));
	endtask

	// mostly allocate small blocks and free addresses taken from the block table model
	task automatic random_phase(input int n, input int hmax);
		logic [ADDR_BITS-1:0] a;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3: add_item(mk(MODE_ALLOC, LEN_BITS'($urandom_range(1, hmax)),
					ADDR_BITS'($urandom)));
				4: add_item(mk(MODE_ALLOC, LEN_BITS'($urandom_range(0, (1 << 17) - 1)),
					ADDR_BITS'($urandom)));
				5, 6, 7, 8: begin
					a = (tbl_count > 0) ? tbl_off[$urandom_range(tbl_count - 1)] : '0;
					drain_peek(a);
				end
				default: add_item(mk(MODE_FREE, LEN_BITS'($urandom), ADDR_BITS'($urandom)));
			endcase
			if (pending_items.size() > 4) while (pending_items.size() > 1) @(posedge clk);
		end
	endtask

	initial begin
		reset_table(HEAP_RESET);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		add_item(mk(MODE_ALLOC, '0, 16'hffff));
		add_item(mk(MODE_ALLOC, 17'h1ffff, '0));
		add_item(mk(MODE_ALLOC, 17'h10000, '0));
		add_item(mk(MODE_FREE, '0, '0));
		add_item(mk(MODE_FREE, 17'h1ffff, '0));
		add_item(mk(MODE_FREE, '0, 16'hffff));
		for (int i = 0; i < 16; i++) add_item(mk(MODE_ALLOC, 17'd1, '0));
		add_item(mk(MODE_FREE, '0, 16'd3));
		add_item(mk(MODE_FREE, '0, 16'd4));
		write_heap('0);
		add_item(mk(MODE_ALLOC, 17'd1, '0));
		add_item(mk(MODE_ALLOC, 17'd1, '0));
		write_heap(17'h1ffff);
		random_phase(300, 9000);
		write_heap(17'd100);
		random_phase(300, 20);
		idle_pct = 0;
		write_heap(17'h10000);
		random_phase(300, 4096);
		idle_pct = 11;
		write_heap(LEN_BITS'($urandom_range(1, 65536)));
		random_phase(450, 3000);
		drain();
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- first_fit_block_allocator.f -----
+incdir+rtl
rtl/ffa_pkg.sv
rtl/ffa_cell.sv
rtl/first_fit_block_allocator.sv
rtl/ffa_checker.sv
tb/tb_top.sv
